// ===== hw/rtl/ctss_pkg.sv =====
// Shared types, codes and helpers for the color triggered stepper sorter.
// Used by every module in hw/rtl; depends on nothing.
package ctss_pkg;

    localparam int DELAY_BITS = 16;
    localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_BITS) - 33'd1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WAIT = 3'd1,
        PH_OUT  = 3'd2,
        PH_HOLD = 3'd3,
        PH_HOME = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        COL_NONE = 2'd0,
        COL_RED  = 2'd1,
        COL_BLUE = 2'd2
    } color_t;

    typedef enum logic [2:0] {
        REG_WAIT_TICKS  = 3'd0,
        REG_HOLD_TICKS  = 3'd1,
        REG_HALF_PERIOD = 3'd2,
        REG_STEPS       = 3'd3,
        REG_MIN_CLEAR   = 3'd4,
        REG_DOMINANCE   = 3'd5,
        REG_REARM       = 3'd6,
        REG_RED_DIR     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] wait_ticks;
        logic [15:0] hold_ticks;
        logic [7:0]  half_period_ticks;
        logic [11:0] steps_per_move;
        logic [15:0] min_clear;
        logic [7:0]  dominance_percent;
        logic [3:0]  rearm_count;
        logic        red_direction;
    } cfg_t;

    // one output word
    typedef struct packed {
        color_t detected_color;
        phase_t sequence_phase;
        logic   driver_enabled;
        logic   direction_line;
        logic   step_line;
    } result_t;

    // delay counter load, saturating at the counter's maximum
    function automatic logic [DELAY_BITS-1:0] delay_load(input logic [15:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > DELAY_MAX)
            return DELAY_BITS'(DELAY_MAX);
        else
            return DELAY_BITS'(w);
    endfunction

endpackage

// ===== hw/rtl/ctss_cfg.sv =====
// Configuration register file for the sorter.
// Depends on ctss_pkg.
module ctss_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output ctss_pkg::cfg_t      cfg
);

    ctss_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_ticks        <= 16'd5000;
            cfg_reg.hold_ticks        <= 16'd1000;
            cfg_reg.half_period_ticks <= 8'd2;
            cfg_reg.steps_per_move    <= 12'd50;
            cfg_reg.min_clear         <= 16'd150;
            cfg_reg.dominance_percent <= 8'd125;
            cfg_reg.rearm_count       <= 4'd3;
            cfg_reg.red_direction     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (ctss_pkg::reg_idx_t'(cfg_index))
                ctss_pkg::REG_WAIT_TICKS:  cfg_reg.wait_ticks        <= cfg_data;
                ctss_pkg::REG_HOLD_TICKS:  cfg_reg.hold_ticks        <= cfg_data;
                ctss_pkg::REG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data[7:0];
                ctss_pkg::REG_STEPS:       cfg_reg.steps_per_move    <= cfg_data[11:0];
                ctss_pkg::REG_MIN_CLEAR:   cfg_reg.min_clear         <= cfg_data;
                ctss_pkg::REG_DOMINANCE:   cfg_reg.dominance_percent <= cfg_data[7:0];
                ctss_pkg::REG_REARM:       cfg_reg.rearm_count       <= cfg_data[3:0];
                ctss_pkg::REG_RED_DIR:     cfg_reg.red_direction     <= cfg_data[0];
                default:                   cfg_reg.red_direction     <= cfg_reg.red_direction;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/ctss_classify.sv =====
// Color classifier: clear threshold, red/blue dominance ratio test and a check against green.
// Depends on ctss_pkg.
module ctss_classify (
    input  logic [15:0]      clear_level,
    input  logic [15:0]      red_level,
    input  logic [15:0]      green_level,
    input  logic [15:0]      blue_level,
    input  logic [15:0]      min_clear,
    input  logic [7:0]       dominance_percent,
    output ctss_pkg::color_t color
);

    logic [23:0] red_x100;
    logic [23:0] blue_x100;
    logic [23:0] red_xdom;
    logic [23:0] blue_xdom;

    assign red_x100  = 24'(red_level) * 24'd100;
    assign blue_x100 = 24'(blue_level) * 24'd100;
    assign red_xdom  = 24'(red_level) * 24'(dominance_percent);
    assign blue_xdom = 24'(blue_level) * 24'(dominance_percent);

    always_comb
    begin
        priority if (clear_level < min_clear)
            color = ctss_pkg::COL_NONE;
        else if (red_x100 > blue_xdom && red_level > green_level)
            color = ctss_pkg::COL_RED;
        else if (blue_x100 > red_xdom && blue_level > green_level)
            color = ctss_pkg::COL_BLUE;
        else
            color = ctss_pkg::COL_NONE;
    end

endmodule

// ===== hw/rtl/ctss_seq.sv =====
// Detection arming and stepper sequence state, one update per tick word.
// Depends on ctss_pkg.
module ctss_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                sample_valid,
    input  ctss_pkg::color_t    color,
    input  ctss_pkg::cfg_t      cfg,
    output ctss_pkg::result_t   result
);

    ctss_pkg::phase_t                   phase_reg, phase_next;
    ctss_pkg::color_t                   move_color_reg, move_color_next;
    ctss_pkg::color_t                   last_color_reg, last_color_next;
    logic [ctss_pkg::DELAY_BITS-1:0]    delay_reg, delay_next;
    logic [7:0]                         toggle_reg, toggle_next;
    logic [11:0]                        steps_reg, steps_next;
    logic                               pulse_reg, pulse_next;
    logic                               out_dir_reg, out_dir_next;
    logic                               dir_reg, dir_next;
    logic                               enabled_reg, enabled_next;
    logic                               armed_reg, armed_next;
    logic [3:0]                         none_reg, none_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ctss_pkg::PH_IDLE;
            move_color_reg <= ctss_pkg::COL_NONE;
            last_color_reg <= ctss_pkg::COL_NONE;
            delay_reg      <= '0;
            toggle_reg     <= '0;
            steps_reg      <= '0;
            pulse_reg      <= 1'b0;
            out_dir_reg    <= 1'b0;
            dir_reg        <= 1'b0;
            enabled_reg    <= 1'b0;
            armed_reg      <= 1'b1;
            none_reg       <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            move_color_reg <= move_color_next;
            last_color_reg <= last_color_next;
            delay_reg      <= delay_next;
            toggle_reg     <= toggle_next;
            steps_reg      <= steps_next;
            pulse_reg      <= pulse_next;
            out_dir_reg    <= out_dir_next;
            dir_reg        <= dir_next;
            enabled_reg    <= enabled_next;
            armed_reg      <= armed_next;
            none_reg       <= none_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        move_color_next = move_color_reg;
        last_color_next = last_color_reg;
        delay_next      = delay_reg;
        toggle_next     = toggle_reg;
        steps_next      = steps_reg;
        pulse_next      = pulse_reg;
        out_dir_next    = out_dir_reg;
        dir_next        = dir_reg;
        enabled_next    = enabled_reg;
        armed_next      = armed_reg;
        none_next       = none_reg;

        // color logic runs first
        if (sample_valid)
        begin
            if (color == ctss_pkg::COL_NONE)
            begin
                if (none_next < cfg.rearm_count)
                    none_next = none_next + 4'd1;
                if (none_next >= cfg.rearm_count)
                    armed_next = 1'b1;
            end
            else
            begin
                none_next = '0;
                if (armed_reg && phase_reg == ctss_pkg::PH_IDLE)
                begin
                    armed_next      = 1'b0;
                    last_color_next = color;
                    move_color_next = color;
                    phase_next      = ctss_pkg::PH_WAIT;
                    delay_next      = ctss_pkg::delay_load(cfg.wait_ticks);
                end
            end
        end

        // then the sequence advances from the updated phase
        unique case (phase_next)
            ctss_pkg::PH_WAIT, ctss_pkg::PH_HOLD:
            begin
                if (delay_next == '0)
                begin
                    if (phase_next == ctss_pkg::PH_WAIT)
                    begin
                        out_dir_next = (move_color_next == ctss_pkg::COL_RED)
                                     ? cfg.red_direction : ~cfg.red_direction;
                        phase_next   = ctss_pkg::PH_OUT;
                    end
                    else
                    begin
                        out_dir_next = ~out_dir_reg;
                        phase_next   = ctss_pkg::PH_HOME;
                    end
                    dir_next     = out_dir_next;
                    enabled_next = 1'b1;
                    pulse_next   = 1'b0;
                    steps_next   = '0;
                    toggle_next  = 8'd1;
                end
                else
                    delay_next = delay_next - {{(ctss_pkg::DELAY_BITS-1){1'b0}}, 1'b1};
            end
            ctss_pkg::PH_OUT, ctss_pkg::PH_HOME:
            begin
                if (toggle_next > 8'd1)
                    toggle_next = toggle_next - 8'd1;
                else
                begin
                    toggle_next = (cfg.half_period_ticks == 8'd0)
                                ? 8'd1 : cfg.half_period_ticks;
                    if (pulse_next)
                    begin
                        pulse_next = 1'b0;
                        if (steps_next >= cfg.steps_per_move)
                        begin
                            if (phase_next == ctss_pkg::PH_OUT)
                            begin
                                phase_next = ctss_pkg::PH_HOLD;
                                delay_next = ctss_pkg::delay_load(
                                    (cfg.hold_ticks == 16'd0) ? 16'd0
                                                              : cfg.hold_ticks - 16'd1);
                            end
                            else
                            begin
                                enabled_next    = 1'b0;
                                phase_next      = ctss_pkg::PH_IDLE;
                                move_color_next = ctss_pkg::COL_NONE;
                            end
                        end
                    end
                    else
                    begin
                        pulse_next = 1'b1;
                        steps_next = steps_next + 12'd1;
                    end
                end
            end
            default:
            begin
                phase_next = phase_next;
            end
        endcase

        result.step_line      = pulse_next;
        result.direction_line = dir_next;
        result.driver_enabled = enabled_next;
        result.sequence_phase = phase_next;
        result.detected_color = last_color_next;
    end

endmodule

// ===== hw/rtl/color_triggered_stepper_sorter_core.sv =====
// Color triggered stepper sorter, top level. Depends on ctss_pkg, ctss_cfg,
// ctss_classify and ctss_seq.
// Each word passes through an input register, then an output register.
// Throughput: 1 word per cycle while m_axis_tready does not stall the output.
// Reset (rst_n, async, active low): empty pipeline, registers at defaults.
module color_triggered_stepper_sorter_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // clear_level, red_level, green_level, blue_level
    input  logic        s_axis_tuser,   // sample_valid

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // step_line, direction_line, driver_enabled,
                                        // sequence_phase[2:0], detected_color[1:0]

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // input stage
    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic        in_sample_reg;

    // output stage
    logic              out_valid_reg;
    ctss_pkg::result_t out_reg;

    logic              advance;
    logic              in_take;
    ctss_pkg::cfg_t    cfg;
    ctss_pkg::color_t  color;
    ctss_pkg::result_t result;

    // the input word moves on when the output register is empty or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg   <= s_axis_tdata;
            in_sample_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    ctss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctss_classify u_classify (
        .clear_level       (in_data_reg[15:0]),
        .red_level         (in_data_reg[31:16]),
        .green_level       (in_data_reg[47:32]),
        .blue_level        (in_data_reg[63:48]),
        .min_clear         (cfg.min_clear),
        .dominance_percent (cfg.dominance_percent),
        .color             (color)
    );

    // sequence state commits only when the word actually moves to the output
    ctss_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .sample_valid (in_sample_reg),
        .color        (color),
        .cfg          (cfg),
        .result       (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // every word that leaves the input stage shows up at the output next cycle
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("word lost between input and output stage");

    // driver is enabled exactly while moving or holding
    a_enable_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.driver_enabled ==
            (out_reg.sequence_phase == ctss_pkg::PH_OUT ||
             out_reg.sequence_phase == ctss_pkg::PH_HOLD ||
             out_reg.sequence_phase == ctss_pkg::PH_HOME)))
        else $error("driver enable out of step with phase");

    // step pulses only while a move is in progress
    a_step_in_move: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.step_line) |->
            (out_reg.sequence_phase == ctss_pkg::PH_OUT ||
             out_reg.sequence_phase == ctss_pkg::PH_HOME))
        else $error("step pulse outside a move");

endmodule
